>>> hw/rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants of the sorted region table: field widths,
// operation and error codes, table entry layout, controller/datapath bundles.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int PAGE_W     = 20;
  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int FUNC_W     = 2;
  localparam int ERR_W      = 2;

  // base of the application area; the top walk starts here
  localparam logic [ADDR_W-1:0] AREA_BASE      = 32'h0000_8000;
  localparam logic [ADDR_W-1:0] APP_LIMIT_INIT = 32'h8000_0000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_TOP    = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK     = 2'd0,
    ERR_FULL   = 2'd1,
    ERR_SHRINK = 2'd2
  } err_t;

  typedef struct packed {
    logic [PAGE_W-1:0] start;
    logic [PAGE_W-1:0] len;
    logic [PAGE_W-1:0] phys;
    logic              dev;
  } entry_t;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_ZERO = 3'd1,
    IDX_INC  = 3'd2,
    IDX_DEC  = 3'd3,
    IDX_LAST = 3'd4
  } idx_op_t;

  typedef struct packed {
    logic    capture;      // latch the incoming transaction
    logic    clear_res;    // zero the result being built
    logic    top_init;     // top <= AREA_BASE
    logic    top_load;     // top <= end of current entry
    logic    pl_ins_load;  // placement params from a device insert
    logic    pl_grow_load; // placement params from area growth
    logic    pos_load;     // pos <= idx
    logic    shift_wr;     // copy entry idx-1 up to idx
    logic    entry_wr;     // write new entry at pos
    logic    res_top_walk; // result top <= walked top
    logic    res_top_va;   // result top <= requested top
    logic    err_full;
    logic    err_shrink;
    logic    blk_load;     // result block <= current entry
    logic    out_load;     // move result to the output register
    logic    rd_below;     // read port one below idx_next
    idx_op_t idx_op;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              limit_ok;
    logic              walk_go;
    logic              idx_last;
    logic              va_zero;
    logic              va_gt_top;
    logic              va_lt_top;
    logic              ps_stop;
    logic              ne_idx;
    logic              ne_last;
    logic              sh_copy;
    logic              sh_end;
    logic              lk_hit;
    logic              out_free;
  } status_t;

endpackage

>>> hw/rtl/srt_if.sv
// ----------------------------------------------------------------------------
// srt channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srt_req_if;
  logic                           valid;
  logic                           ready;
  logic [srt_pkg::FUNC_W-1:0]     func;
  logic [srt_pkg::ADDR_W-1:0]     va;
  logic [srt_pkg::PAGE_W-1:0]     phys_page;
  logic [srt_pkg::PAGE_W-1:0]     page_count;

  modport source (output valid, func, va, phys_page, page_count, input ready);
  modport sink   (input valid, func, va, phys_page, page_count, output ready);
endinterface

interface srt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [srt_pkg::ADDR_W-1:0]     top;
  logic                           found;
  logic [srt_pkg::PAGE_W-1:0]     blk_va_page;
  logic [srt_pkg::PAGE_W-1:0]     blk_pages;
  logic [srt_pkg::PAGE_W-1:0]     blk_phys_page;
  logic                           blk_device;
  logic [srt_pkg::ERR_W-1:0]      error;

  modport source (output valid, top, found, blk_va_page, blk_pages, blk_phys_page,
                  blk_device, error, input ready);
  modport sink   (input valid, top, found, blk_va_page, blk_pages, blk_phys_page,
                  blk_device, error, output ready);
endinterface

>>> hw/rtl/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl
// Operation sequencer: dispatch, top walk, placement scan, shift, write,
// lookup scan and result hand-off.
// ----------------------------------------------------------------------------
module srt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  srt_pkg::status_t status,
  output srt_pkg::cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_WALK     = 10'b00_0000_0100,
    S_TOPDEC   = 10'b00_0000_1000,
    S_PSCAN    = 10'b00_0001_0000,
    S_SHIFT    = 10'b00_0010_0000,
    S_WRITE    = 10'b00_0100_0000,
    S_FAIL     = 10'b00_1000_0000,
    S_LOOK     = 10'b01_0000_0000,
    S_FINISH   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   grow, grow_next;  // placement comes from area growth

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      grow  <= 1'b0;
    end else begin
      state <= state_next;
      grow  <= grow_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.idx_op = srt_pkg::IDX_HOLD;
    state_next = state;
    grow_next  = grow;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.idx_op = srt_pkg::IDX_ZERO;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.idx_op    = srt_pkg::IDX_ZERO;
        cmd.clear_res = 1'b1;
        grow_next     = 1'b0;
        if (status.func == srt_pkg::FUNC_INSERT) begin
          cmd.pl_ins_load = 1'b1;
          state_next      = S_PSCAN;
        end else if (status.func == srt_pkg::FUNC_TOP) begin
          cmd.top_init = 1'b1;
          state_next   = S_WALK;
        end else if (status.func == srt_pkg::FUNC_LOOKUP && status.limit_ok) begin
          state_next = S_LOOK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_WALK: begin
        if (status.walk_go) begin
          cmd.top_load = 1'b1;
          if (status.idx_last) state_next = S_TOPDEC;
          else cmd.idx_op = srt_pkg::IDX_INC;
        end else begin
          state_next = S_TOPDEC;
        end
      end
      S_TOPDEC: begin
        if (status.va_zero) begin
          cmd.res_top_walk = 1'b1;
          state_next       = S_FINISH;
        end else if (status.va_gt_top) begin
          cmd.pl_grow_load = 1'b1;
          cmd.idx_op       = srt_pkg::IDX_ZERO;
          grow_next        = 1'b1;
          state_next       = S_PSCAN;
        end else begin
          cmd.res_top_walk = 1'b1;
          cmd.err_shrink   = status.va_lt_top;
          state_next       = S_FINISH;
        end
      end
      S_PSCAN: begin
        if (status.ps_stop) begin
          cmd.pos_load = 1'b1;
          if (!status.ne_idx) begin
            state_next = S_WRITE;
          end else if (status.ne_last) begin
            state_next = S_FAIL;
          end else begin
            cmd.idx_op   = srt_pkg::IDX_LAST;
            cmd.rd_below = 1'b1;
            state_next   = S_SHIFT;
          end
        end else if (status.idx_last) begin
          state_next = S_FAIL;
        end else begin
          cmd.idx_op = srt_pkg::IDX_INC;
        end
      end
      S_SHIFT: begin
        cmd.shift_wr = status.sh_copy;
        if (status.sh_end) begin
          state_next = S_WRITE;
        end else begin
          cmd.idx_op   = srt_pkg::IDX_DEC;
          cmd.rd_below = 1'b1;
        end
      end
      S_WRITE: begin
        cmd.entry_wr   = 1'b1;
        cmd.res_top_va = grow;
        state_next     = S_FINISH;
      end
      S_FAIL: begin
        cmd.err_full     = 1'b1;
        cmd.res_top_walk = grow;
        state_next       = S_FINISH;
      end
      S_LOOK: begin
        if (status.lk_hit) begin
          cmd.blk_load = 1'b1;
          state_next   = S_FINISH;
        end else if (!status.ne_idx || status.idx_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.idx_op = srt_pkg::IDX_INC;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/srt_datapath.sv
// ----------------------------------------------------------------------------
// srt_datapath
// Region table memory, occupancy bits, scan index, top and placement
// registers, result builder and output register.
// ----------------------------------------------------------------------------
module srt_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  srt_pkg::cmd_t                  cmd,
  output srt_pkg::status_t               status,
  input  logic [srt_pkg::ADDR_W-1:0]     app_limit,
  input  logic [srt_pkg::FUNC_W-1:0]     in_func,
  input  logic [srt_pkg::ADDR_W-1:0]     in_va,
  input  logic [srt_pkg::PAGE_W-1:0]     in_phys_page,
  input  logic [srt_pkg::PAGE_W-1:0]     in_page_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [srt_pkg::ADDR_W-1:0]     out_top,
  output logic                           out_found,
  output srt_pkg::entry_t                out_blk,
  output logic [srt_pkg::ERR_W-1:0]      out_error
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);
  localparam int PW = srt_pkg::PAGE_W;
  localparam int AW = srt_pkg::ADDR_W;

  // captured transaction
  logic [srt_pkg::FUNC_W-1:0] func_r;
  logic [AW-1:0]              va_r;
  logic [PW-1:0]              phys_r;
  logic [PW-1:0]              cnt_r;

  // table storage; an entry whose occupancy bit is clear is never looked at
  srt_pkg::entry_t            mem [TABLE_DEPTH];
  srt_pkg::entry_t            rdata;
  logic [TABLE_DEPTH-1:0]     ne;

  logic [IW-1:0]              idx, idx_next, idx_prev, rd_addr, wr_addr, pos;
  logic [AW-1:0]              top_r, grow_diff, end_addr, start_addr;
  logic [PW:0]                end_sum;
  logic [PW-1:0]              pl_page, pl_len;
  logic                       pl_dev;
  srt_pkg::entry_t            new_entry, wr_data;
  logic                       wr_en;

  logic [AW-1:0]              res_top;
  logic                       res_found;
  srt_pkg::entry_t            res_blk;
  logic [srt_pkg::ERR_W-1:0]  res_err;

  always_comb begin
    case (cmd.idx_op)
      srt_pkg::IDX_HOLD: idx_next = idx;
      srt_pkg::IDX_ZERO: idx_next = '0;
      srt_pkg::IDX_INC:  idx_next = idx + 1'b1;
      srt_pkg::IDX_DEC:  idx_next = idx - 1'b1;
      srt_pkg::IDX_LAST: idx_next = LAST;
      default:           idx_next = idx;
    endcase
  end

  assign idx_prev   = idx - 1'b1;
  assign rd_addr    = cmd.rd_below ? idx_next - 1'b1 : idx_next;
  assign new_entry  = '{start: pl_page, len: pl_len, phys: phys_r, dev: pl_dev};
  assign wr_en      = cmd.shift_wr | cmd.entry_wr;
  assign wr_addr    = cmd.entry_wr ? pos : idx;
  assign wr_data    = cmd.entry_wr ? new_entry : rdata;
  assign end_sum    = {1'b0, rdata.start} + {1'b0, rdata.len};
  assign end_addr   = {end_sum[PW-1:0], {srt_pkg::PAGE_SHIFT{1'b0}}};
  assign start_addr = {rdata.start, {srt_pkg::PAGE_SHIFT{1'b0}}};
  assign grow_diff  = va_r - top_r;

  // memory: one registered read port, one write port
  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ne        <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (cmd.shift_wr) ne[idx] <= 1'b1;
      if (cmd.entry_wr) ne[pos] <= |pl_len;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      va_r   <= in_va;
      phys_r <= in_phys_page;
      cnt_r  <= in_page_count;
    end
    if (cmd.top_init) top_r <= srt_pkg::AREA_BASE;
    else if (cmd.top_load) top_r <= end_addr;
    if (cmd.pl_ins_load) begin
      pl_page <= va_r[AW-1:srt_pkg::PAGE_SHIFT];
      pl_len  <= cnt_r;
      pl_dev  <= 1'b1;
    end else if (cmd.pl_grow_load) begin
      pl_page <= top_r[AW-1:srt_pkg::PAGE_SHIFT];
      pl_len  <= grow_diff[AW-1:srt_pkg::PAGE_SHIFT];
      pl_dev  <= 1'b0;
    end
    if (cmd.pos_load) pos <= idx;
    if (cmd.clear_res) begin
      res_top   <= '0;
      res_found <= 1'b0;
      res_blk   <= '0;
      res_err   <= srt_pkg::ERR_OK;
    end else begin
      if (cmd.res_top_walk) res_top <= top_r;
      else if (cmd.res_top_va) res_top <= va_r;
      if (cmd.err_full) res_err <= srt_pkg::ERR_FULL;
      else if (cmd.err_shrink) res_err <= srt_pkg::ERR_SHRINK;
      if (cmd.blk_load) begin
        res_found <= 1'b1;
        res_blk   <= rdata;
      end
    end
    if (cmd.out_load) begin
      out_top   <= res_top;
      out_found <= res_found;
      out_blk   <= res_blk;
      out_error <= res_err;
    end
  end

  always_comb begin
    status           = '0;
    status.func      = func_r;
    status.limit_ok  = va_r < app_limit;
    status.walk_go   = ne[idx] && (rdata.start <= top_r[AW-1:srt_pkg::PAGE_SHIFT]);
    status.idx_last  = idx == LAST;
    status.va_zero   = va_r == '0;
    status.va_gt_top = va_r > top_r;
    status.va_lt_top = va_r < top_r;
    status.ps_stop   = !ne[idx] || (rdata.start >= pl_page);
    status.ne_idx    = ne[idx];
    status.ne_last   = ne[TABLE_DEPTH-1];
    status.sh_copy   = ne[idx_prev];
    status.sh_end    = idx_prev == pos;
    status.lk_hit    = ne[idx] && (va_r >= start_addr) && (va_r < end_addr);
    status.out_free  = !out_valid || out_ready;
  end

endmodule

>>> hw/rtl/sorted_region_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_region_table_unit
// Per-task table of virtual memory regions kept sorted by start page, with
// device insert, application top walk/grow and address lookup.
// ----------------------------------------------------------------------------
// The unit handles one transaction at a time. Every operation runs through a
// table memory with one registered read port and one write port, at one
// entry per clock: lookup scans up to TABLE_DEPTH entries, insert scans for
// the slot and then moves entries up (the two together never exceed
// TABLE_DEPTH entries), and set top walks up to TABLE_DEPTH entries and adds
// a decision step in front of a possible insert. The table comes up empty
// straight out of reset (per-entry occupancy flops), so there is no clearing
// pass. A finished result sits in an output register; the next request is
// taken while it waits, and the unit only stalls at the end of that next
// operation if the result is still untaken. app_limit is written over APB at
// byte address 0 and must only change while the unit is idle.
// ----------------------------------------------------------------------------
module sorted_region_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  srt_req_if.sink     req,
  srt_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_APP_LIMIT = 1'b0;  // register index, paddr[2]

  srt_pkg::cmd_t    cmd;
  srt_pkg::status_t status;
  srt_pkg::entry_t  out_blk;
  logic [31:0]      app_limit;
  logic             apb_wr;

  // --- configuration: app_limit, write on the access phase
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      app_limit <= srt_pkg::APP_LIMIT_INIT;
    end else if (apb_wr && paddr[2] == REG_APP_LIMIT) begin
      app_limit <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_APP_LIMIT) ? app_limit : '0;

  // --- sequencer
  srt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // --- table, scan registers and result/output registers
  srt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .app_limit     (app_limit),
    .in_func       (req.func),
    .in_va         (req.va),
    .in_phys_page  (req.phys_page),
    .in_page_count (req.page_count),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_top       (rsp.top),
    .out_found     (rsp.found),
    .out_blk       (out_blk),
    .out_error     (rsp.error)
  );

  assign rsp.blk_va_page   = out_blk.start;
  assign rsp.blk_pages     = out_blk.len;
  assign rsp.blk_phys_page = out_blk.phys;
  assign rsp.blk_device    = out_blk.dev;

  // --- checks
  // a request is never taken twice: the sequencer leaves idle on accept
  a_one_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted on consecutive cycles");

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("pending result overwritten");

  // new entry and shift never share the write port
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    cmd.entry_wr |-> !cmd.shift_wr && !cmd.out_load)
    else $error("write port conflict");

  // a taken result with nothing new loaded leaves the output empty
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready && !cmd.out_load |=> !rsp.valid)
    else $error("result delivered twice");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_region_table_unit. A short table of directed
// operations is followed by randomized insert, top and lookup traffic in
// phases with different app_limit settings. Every response is checked against
// an in-bench model or a typed row's own expectation while channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = 16;
  localparam int HOLD_CYCLES  = 200;        // long response hold-off
  localparam int DRAIN_CYCLES = 64;         // quiet wait for late responses at the end
  localparam int TIMEOUT_NS   = 1_000_000;
  localparam int SHOW_LIMIT   = 10;         // mismatches printed in full

  // the func field is two bits wide; code 3 has no operation behind it
  localparam logic [srt_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // APB register map
  localparam logic [2:0] REG_APP_LIMIT = 3'd0;

  typedef struct packed {
    logic [srt_pkg::FUNC_W-1:0] func;
    logic [srt_pkg::ADDR_W-1:0] va;
    logic [srt_pkg::PAGE_W-1:0] phys;
    logic [srt_pkg::PAGE_W-1:0] cnt;
  } table_req_t;

  typedef struct packed {
    logic [srt_pkg::ADDR_W-1:0] top;
    logic                       found;
    logic [srt_pkg::PAGE_W-1:0] va_page;
    logic [srt_pkg::PAGE_W-1:0] pages;
    logic [srt_pkg::PAGE_W-1:0] phys_page;
    logic                       dev;
    srt_pkg::err_t              error;
  } table_rsp_t;

  // one row of the directed table; exp is used only where typed is set
  typedef struct packed {
    table_req_t op;
    logic       typed;
    table_rsp_t exp;
  } dir_row_t;

  localparam table_rsp_t RSP_ZERO = '0;

  // Directed sequence, starting from an empty table and the reset app_limit.
  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty table: lookup misses, top query reports the area base
    '{'{srt_pkg::FUNC_LOOKUP, 32'h0000_8000, 20'h00000, 20'h00000}, 1'b1, RSP_ZERO},
    '{'{srt_pkg::FUNC_TOP, 32'h0000_0000, 20'h00000, 20'h00000}, 1'b1,
      '{32'h0000_8000, 1'b0, 20'h0, 20'h0, 20'h0, 1'b0, srt_pkg::ERR_OK}},
    // unused code with every input bit set: nothing happens
    '{'{FUNC_UNUSED, 32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF}, 1'b1, RSP_ZERO},
    // shrink below the base is refused
    '{'{srt_pkg::FUNC_TOP, 32'h0000_4000, 20'h00000, 20'h00000}, 1'b1,
      '{32'h0000_8000, 1'b0, 20'h0, 20'h0, 20'h0, 1'b0, srt_pkg::ERR_SHRINK}},
    // grow by 8 pages, then query and look inside the new region
    '{'{srt_pkg::FUNC_TOP, 32'h0001_0000, 20'h12345, 20'h00000}, 1'b1,
      '{32'h0001_0000, 1'b0, 20'h0, 20'h0, 20'h0, 1'b0, srt_pkg::ERR_OK}},
    '{'{srt_pkg::FUNC_TOP, 32'h0000_0000, 20'h00000, 20'h00000}, 1'b1,
      '{32'h0001_0000, 1'b0, 20'h0, 20'h0, 20'h0, 1'b0, srt_pkg::ERR_OK}},
    '{'{srt_pkg::FUNC_LOOKUP, 32'h0000_8000, 20'h00000, 20'h00000}, 1'b1,
      '{32'h0, 1'b1, 20'h00008, 20'h00008, 20'h12345, 1'b0, srt_pkg::ERR_OK}},
    '{'{srt_pkg::FUNC_LOOKUP, 32'h0000_FFFF, 20'h00000, 20'h00000}, 1'b1,
      '{32'h0, 1'b1, 20'h00008, 20'h00008, 20'h12345, 1'b0, srt_pkg::ERR_OK}},
    '{'{srt_pkg::FUNC_LOOKUP, 32'h0001_0000, 20'h00000, 20'h00000}, 1'b1, RSP_ZERO},
    // request equal to the current top: no change, no error
    '{'{srt_pkg::FUNC_TOP, 32'h0001_0000, 20'h0BEEF, 20'h00000}, 1'b1,
      '{32'h0001_0000, 1'b0, 20'h0, 20'h0, 20'h0, 1'b0, srt_pkg::ERR_OK}},
    // device page just under the default limit
    '{'{srt_pkg::FUNC_INSERT, 32'h7FFF_F000, 20'hFFFFF, 20'h00001}, 1'b1, RSP_ZERO},
    '{'{srt_pkg::FUNC_LOOKUP, 32'h7FFF_FFFF, 20'h00000, 20'h00000}, 1'b1,
      '{32'h0, 1'b1, 20'h7FFFF, 20'h00001, 20'hFFFFF, 1'b1, srt_pkg::ERR_OK}},
    // lookup at the limit finds nothing
    '{'{srt_pkg::FUNC_LOOKUP, 32'h8000_0000, 20'h00000, 20'h00000}, 1'b1, RSP_ZERO},
    // insert at the front shifts everything up
    '{'{srt_pkg::FUNC_INSERT, 32'h0000_0FFF, 20'h00000, 20'h00004}, 1'b1, RSP_ZERO},
    // region at page 0 breaks the walk from the base
    '{'{srt_pkg::FUNC_TOP, 32'h0000_0000, 20'h00000, 20'h00000}, 1'b0, RSP_ZERO},
    '{'{srt_pkg::FUNC_TOP, 32'h0001_0000, 20'h00ABC, 20'h00000}, 1'b0, RSP_ZERO},
    // zero-length insert leaves a hole that hides later entries
    '{'{srt_pkg::FUNC_INSERT, 32'h0000_9000, 20'h00055, 20'h00000}, 1'b0, RSP_ZERO},
    '{'{srt_pkg::FUNC_LOOKUP, 32'h7FFF_F800, 20'h00000, 20'h00000}, 1'b0, RSP_ZERO},
    // largest page and length: fills the hole, end address wraps
    '{'{srt_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 20'hABCDE, 20'hFFFFF}, 1'b0, RSP_ZERO},
    '{'{srt_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 20'h00000, 20'h00000}, 1'b1, RSP_ZERO},
    '{'{srt_pkg::FUNC_INSERT, 32'h0010_0000, 20'h0F0F0, 20'h00020}, 1'b0, RSP_ZERO},
    '{'{srt_pkg::FUNC_TOP, 32'h0000_2000, 20'h00000, 20'h00000}, 1'b0, RSP_ZERO},
    '{'{srt_pkg::FUNC_LOOKUP, 32'h0000_0000, 20'h00000, 20'h00000}, 1'b0, RSP_ZERO}
  };

  // random phases: app_limit setting and transaction count per phase;
  // the last phase runs without idling and inserts often to fill the table
  localparam int PHASES = 5;
  localparam int PHASE_LEN [PHASES] = '{110, 60, 110, 110, 110};

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  srt_req_if req_ch ();
  srt_rsp_if rsp_ch ();

  sorted_region_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Region table model: bench copy of the table and of app_limit
  // --------------------------------------------------------------------------
  logic [srt_pkg::PAGE_W-1:0] tbl_start [TABLE_DEPTH];
  logic [srt_pkg::PAGE_W-1:0] tbl_len   [TABLE_DEPTH];
  logic [srt_pkg::PAGE_W-1:0] tbl_phys  [TABLE_DEPTH];
  logic                       tbl_dev   [TABLE_DEPTH];
  logic [srt_pkg::ADDR_W-1:0] limit_shadow;

  // responses still owed by the unit, oldest first
  table_rsp_t awaited_rsp [$];

  // control shared between processes; written by the stimulus process only
  bit req_idling;
  bit rsp_idling;
  int hold_req;

  // bookkeeping
  int fail_count;
  int rsp_seen;
  int op_count [4];
  int err_seen [4];
  int hit_count;
  int cfg_writes;

  // end address of an entry: (start + len) pages, wrapping at 4 GiB
  function automatic logic [srt_pkg::ADDR_W-1:0] region_end_addr(int k);
    logic [srt_pkg::ADDR_W-1:0] s;
    s = {12'h000, tbl_start[k]} + {12'h000, tbl_len[k]};
    return s << srt_pkg::PAGE_SHIFT;
  endfunction

  // sorted placement; returns 0 when the table cannot take the entry
  function automatic bit place_region(logic [srt_pkg::ADDR_W-1:0] addr,
                                      logic [srt_pkg::PAGE_W-1:0] len,
                                      logic [srt_pkg::PAGE_W-1:0] phys, logic dev);
    logic [srt_pkg::PAGE_W-1:0] page;
    int pos;
    page = addr[srt_pkg::ADDR_W-1:srt_pkg::PAGE_SHIFT];
    pos = 0;
    while (pos < TABLE_DEPTH && tbl_len[pos] != '0 && tbl_start[pos] < page)
      pos++;
    if (pos >= TABLE_DEPTH)
      return 1'b0;
    if (tbl_len[pos] != '0) begin
      if (tbl_len[TABLE_DEPTH-1] != '0)
        return 1'b0;
      // empty entries are not moved up
      for (int j = TABLE_DEPTH - 1; j > pos; j--) begin
        if (tbl_len[j-1] != '0) begin
          tbl_start[j] = tbl_start[j-1];
          tbl_len[j]   = tbl_len[j-1];
          tbl_phys[j]  = tbl_phys[j-1];
          tbl_dev[j]   = tbl_dev[j-1];
        end
      end
    end
    tbl_start[pos] = page;
    tbl_len[pos]   = len;
    tbl_phys[pos]  = phys;
    tbl_dev[pos]   = dev;
    return 1'b1;
  endfunction

  // top of the area: follow entries contiguous from the base
  function automatic logic [srt_pkg::ADDR_W-1:0] walked_top();
    logic [srt_pkg::ADDR_W-1:0] t;
    int k;
    t = srt_pkg::AREA_BASE;
    k = 0;
    while (k < TABLE_DEPTH && tbl_len[k] != '0 &&
           tbl_start[k] <= t[srt_pkg::ADDR_W-1:srt_pkg::PAGE_SHIFT]) begin
      t = region_end_addr(k);
      k++;
    end
    return t;
  endfunction

  // applies one operation to the model table and returns its response
  function automatic table_rsp_t apply_table_op(table_req_t r);
    table_rsp_t res;
    logic [srt_pkg::ADDR_W-1:0] t;
    logic [srt_pkg::ADDR_W-1:0] grow;
    int k;
    res = '0;
    case (r.func)
      srt_pkg::FUNC_INSERT: begin
        if (!place_region(r.va, r.cnt, r.phys, 1'b1))
          res.error = srt_pkg::ERR_FULL;
      end
      srt_pkg::FUNC_TOP: begin
        t = walked_top();
        if (r.va != '0) begin
          if (r.va > t) begin
            grow = (r.va - t) >> srt_pkg::PAGE_SHIFT;
            if (place_region(t, grow[srt_pkg::PAGE_W-1:0], r.phys, 1'b0))
              t = r.va;
            else
              res.error = srt_pkg::ERR_FULL;
          end else if (r.va < t) begin
            res.error = srt_pkg::ERR_SHRINK;
          end
        end
        res.top = t;
      end
      srt_pkg::FUNC_LOOKUP: begin
        if (r.va < limit_shadow) begin
          k = 0;
          while (k < TABLE_DEPTH && tbl_len[k] != '0 &&
                 !(r.va >= {tbl_start[k], 12'h000} && r.va < region_end_addr(k)))
            k++;
          if (k < TABLE_DEPTH && tbl_len[k] != '0) begin
            res.found     = 1'b1;
            res.va_page   = tbl_start[k];
            res.pages     = tbl_len[k];
            res.phys_page = tbl_phys[k];
            res.dev       = tbl_dev[k];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random operation, shaped by the model state: most lookups land inside a
  // live entry, top requests are mostly grow/query/shrink around the current
  // top. fill_pct sets how often an insert or a growth is tried.
  function automatic table_req_t rand_table_req(int fill_pct);
    table_req_t r;
    logic [srt_pkg::ADDR_W-1:0] t;
    int roll;
    int pick;
    int k;
    r.phys = srt_pkg::PAGE_W'($urandom);
    r.cnt  = '0;
    r.va   = '0;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    k    = $urandom_range(0, TABLE_DEPTH - 1);
    if (roll < 3) begin
      r.func = FUNC_UNUSED;
      r.va   = $urandom;
      r.cnt  = srt_pkg::PAGE_W'($urandom);
    end else if (roll < 3 + fill_pct) begin
      r.func = srt_pkg::FUNC_INSERT;
      if (pick < 3)
        r.va = $urandom;
      else if (pick < 5)
        r.va = {tbl_start[k], 12'h000};         // same start page as an entry
      else
        r.va = srt_pkg::AREA_BASE + ($urandom_range(0, 511) << srt_pkg::PAGE_SHIFT) +
               $urandom_range(0, 4095);
      pick = $urandom_range(0, 9);
      if (pick == 0)
        r.cnt = '0;
      else if (pick == 1)
        r.cnt = srt_pkg::PAGE_W'($urandom);
      else
        r.cnt = srt_pkg::PAGE_W'($urandom_range(1, 32));
    end else if (roll < 3 + 2 * fill_pct) begin
      // growth
      r.func = srt_pkg::FUNC_TOP;
      t = walked_top();
      if (pick == 0)
        r.va = $urandom;
      else
        r.va = t + ($urandom_range(1, 16) << srt_pkg::PAGE_SHIFT) +
               ($urandom_range(0, 1) ? $urandom_range(0, 4095) : 0);
    end else if (roll < 18 + 2 * fill_pct) begin
      // query or shrink
      r.func = srt_pkg::FUNC_TOP;
      t = walked_top();
      if (pick < 6)
        r.va = '0;
      else if (t > 32'd1)
        r.va = $urandom_range(1, t - 1);
      else
        r.va = $urandom;
    end else begin
      r.func = srt_pkg::FUNC_LOOKUP;
      if (pick < 7 && tbl_len[k] != '0)
        r.va = {tbl_start[k], 12'h000} +
               ($urandom % ({12'h000, tbl_len[k]} << srt_pkg::PAGE_SHIFT));
      else if (pick == 7)
        r.va = limit_shadow + $urandom_range(0, 2) - 1;
      else
        r.va = $urandom;
    end
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT)
      $display("%0t ns: MISMATCH %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and the limit on run time
  // --------------------------------------------------------------------------
  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout: %0d responses still outstanding", awaited_rsp.size());
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side: ready generation. Random stall bursts while rsp_idling
  // is set; on each new hold request the unit's output is held blocked so
  // the request side backs up.
  // --------------------------------------------------------------------------
  initial begin : rsp_ready_gen
    int stall;
    int hold_seen;
    stall = 0;
    hold_seen = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rsp_idling)
        stall = 0;
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else if (rsp_idling && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 11) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response checker: each response transaction against the oldest
  // outstanding expectation, field by field
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_check
    table_rsp_t got;
    table_rsp_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got = {rsp_ch.top, rsp_ch.found, rsp_ch.blk_va_page, rsp_ch.blk_pages,
             rsp_ch.blk_phys_page, rsp_ch.blk_device, rsp_ch.error};
      if (awaited_rsp.size() == 0) begin
        note_mismatch($sformatf("response with none outstanding: top=%h found=%b err=%0d",
                                got.top, got.found, got.error));
      end else begin
        want = awaited_rsp.pop_front();
        rsp_seen++;
        if (got.top !== want.top || got.found !== want.found ||
            got.va_page !== want.va_page || got.pages !== want.pages ||
            got.phys_page !== want.phys_page || got.dev !== want.dev ||
            got.error !== want.error)
          note_mismatch({
            $sformatf("rsp %0d exp top=%h found=%b blk=%h/%h/%h dev=%b err=%0d",
                      rsp_seen, want.top, want.found, want.va_page, want.pages,
                      want.phys_page, want.dev, want.error),
            $sformatf(" got top=%h found=%b blk=%h/%h/%h dev=%b err=%0d",
                      got.top, got.found, got.va_page, got.pages,
                      got.phys_page, got.dev, got.error)});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side and APB
  // --------------------------------------------------------------------------

  // Offers one request transaction, after an optional random gap, and
  // records the expected response once it is taken. A typed row supplies its
  // own expectation; the model still runs to keep its table current.
  task automatic send_op(table_req_t r, logic use_typed, table_rsp_t typed_rsp);
    table_rsp_t pred;
    int gap;
    gap = (req_idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.func       <= r.func;
    req_ch.va         <= r.va;
    req_ch.phys_page  <= r.phys;
    req_ch.page_count <= r.cnt;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pred = apply_table_op(r);
    awaited_rsp.push_back(use_typed ? typed_rsp : pred);
    op_count[r.func]++;
    err_seen[pred.error]++;
    if (pred.found)
      hit_count++;
  endtask

  // stop offering and wait until every outstanding response has arrived
  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  // one APB transfer: setup phase, then access phase until pready
  task automatic apb_xfer(logic wr, logic [2:0] addr, logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic verify_app_limit();
    logic [31:0] rd;
    apb_xfer(1'b0, REG_APP_LIMIT, 32'h0, rd);
    if (rd !== limit_shadow)
      note_mismatch($sformatf("app_limit readback exp=%h got=%h", limit_shadow, rd));
  endtask

  // only called with the unit idle
  task automatic set_app_limit(logic [31:0] value);
    logic [31:0] unused_rd;
    apb_xfer(1'b1, REG_APP_LIMIT, value, unused_rd);
    limit_shadow = value;
    cfg_writes++;
    verify_app_limit();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] phase_limit [PHASES];
    int mode;
    bit quiet_phase;

    // every input known from time zero
    rst = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.func       = '0;
    req_ch.va         = '0;
    req_ch.phys_page  = '0;
    req_ch.page_count = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    req_idling = 1'b0;
    rsp_idling = 1'b0;
    hold_req   = 0;
    fail_count = 0;
    rsp_seen   = 0;
    hit_count  = 0;
    cfg_writes = 0;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (err_seen[i]) err_seen[i] = 0;

    // model comes up empty with the reset limit
    limit_shadow = srt_pkg::APP_LIMIT_INIT;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_start[i] = '0;
      tbl_len[i]   = '0;
      tbl_phys[i]  = '0;
      tbl_dev[i]   = 1'b0;
    end

    // extremes first, then a window over the low area, a full-range value,
    // and back to the reset value
    phase_limit[0] = 32'hFFFF_FFFF;
    phase_limit[1] = 32'h0000_0000;
    phase_limit[2] = $urandom_range(32'h0000_8000, 32'h0020_0000);
    phase_limit[3] = $urandom;
    phase_limit[4] = srt_pkg::APP_LIMIT_INIT;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    verify_app_limit();

    // directed rows, with both sides idling at random
    req_idling = 1'b1;
    rsp_idling = 1'b1;
    foreach (DIR_TABLE[i])
      send_op(DIR_TABLE[i].op, DIR_TABLE[i].typed, DIR_TABLE[i].exp);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      set_app_limit(phase_limit[p]);
      quiet_phase = (p == PHASES - 1);
      req_idling  = !quiet_phase;
      rsp_idling  = !quiet_phase;
      for (int n = 0; n < PHASE_LEN[p]; n++) begin
        // idling pattern changes every 25 transactions, including none
        if (!quiet_phase && n % 25 == 0) begin
          mode = $urandom_range(0, 3);
          req_idling = mode[0];
          rsp_idling = mode[1];
        end
        // back up the unit: output blocked while requests keep coming
        if (p == 0 && n == 40) begin
          req_idling = 1'b0;
          hold_req++;
        end
        // request side goes quiet until the unit has nothing left
        if (p == 2 && n == 55)
          drain_results();
        send_op(rand_table_req(quiet_phase ? 25 : 2), 1'b0, RSP_ZERO);
      end
      drain_results();
    end

    // late responses would show up here as unexpected
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d inserts, %0d top requests, %0d lookups (%0d hits), %0d unused codes",
             op_count[srt_pkg::FUNC_INSERT], op_count[srt_pkg::FUNC_TOP],
             op_count[srt_pkg::FUNC_LOOKUP], hit_count, op_count[FUNC_UNUSED]);
    $display("Errors expected: %0d table full, %0d shrink; %0d app_limit writes, %0d mismatches",
             err_seen[srt_pkg::ERR_FULL], err_seen[srt_pkg::ERR_SHRINK], cfg_writes,
             fail_count);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
